[rtl/core/tkpd_pkg.sv]
// Shared types and constants for the touch key pattern debouncer.
package tkpd_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 16;
    localparam int DELAY_WIDTH         = 16;
    localparam int CFG_INDEX_WIDTH     = 2;
    localparam int NUM_PATTERNS        = 6;

    localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = 16'd500;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESS_DELAY   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNKNOWN_DELAY = 2'd1;

    // Pin patterns as {cold, warm, hot, hotlock}; a 0 means touched.
    localparam logic [3:0] PAT_HOTLOCK = 4'hE;
    localparam logic [3:0] PAT_HOT     = 4'hD;
    localparam logic [3:0] PAT_SODA    = 4'hB;
    localparam logic [3:0] PAT_COOL    = 4'h7;
    localparam logic [3:0] PAT_COMBO   = 4'h5;
    localparam logic [3:0] PAT_ALL     = 4'h1;
    localparam logic [3:0] PAT_NONE    = 4'hF;

    // Slots of the per-pattern countdown counters.
    localparam int SLOT_HOTLOCK = 0;
    localparam int SLOT_HOT     = 1;
    localparam int SLOT_SODA    = 2;
    localparam int SLOT_COOL    = 3;
    localparam int SLOT_COMBO   = 4;
    localparam int SLOT_ALL     = 5;

    // Combo press codes.
    localparam logic [1:0] COMBO_NONE     = 2'd0;
    localparam logic [1:0] COMBO_PRESSED  = 2'd1;
    localparam logic [1:0] COMBO_PROMOTED = 2'd2;

    typedef struct packed {
        logic hotlock_pin;
        logic hot_pin;
        logic warm_pin;
        logic cold_pin;
    } t_keys_in;

    typedef struct packed {
        logic       hotlock_press;
        logic       hot_press;
        logic       soda_press;
        logic       cool_press;
        logic [1:0] combo_press;
        logic       all_press;
        logic       any_pushed;
    } t_keys_out;

endpackage

[rtl/core/touch_key_pattern_debouncer_core.sv]
// Touch key pattern debouncer: pattern match, countdown counters and press flags.
// A result beat is registered and valid in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the press flag register doubles as the
// output register, so a new beat is taken whenever the result is empty or taken.
// Reset (synchronous, active low): all counters and flags clear, both delay
// registers load 500, and no result is pending.
module touch_key_pattern_debouncer_core #(
    parameter int COUNT_WIDTH = tkpd_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  tkpd_pkg::t_keys_in                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output tkpd_pkg::t_keys_out                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tkpd_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [tkpd_pkg::DELAY_WIDTH-1:0]     i_cfg_data
);

    localparam int NP = tkpd_pkg::NUM_PATTERNS;

    logic [tkpd_pkg::DELAY_WIDTH-1:0] r_press_delay;
    logic [tkpd_pkg::DELAY_WIDTH-1:0] r_unknown_delay;

    logic [COUNT_WIDTH-1:0] r_cnt [NP];
    logic [COUNT_WIDTH-1:0] n_cnt [NP];
    logic [COUNT_WIDTH-1:0] r_unknown_cnt;
    logic [COUNT_WIDTH-1:0] n_unknown_cnt;

    tkpd_pkg::t_keys_out r_flags;
    tkpd_pkg::t_keys_out n_flags;
    logic                r_out_valid;

    logic [COUNT_WIDTH-1:0] w_press_reload;
    logic [COUNT_WIDTH-1:0] w_unknown_reload;
    logic [3:0]             w_pat;
    logic [NP-1:0]          w_sel;
    logic [NP-1:0]          w_zero;
    logic                   w_is_none;
    logic                   w_is_unknown;
    logic                   w_hit_zero;
    logic                   w_unknown_fire;
    logic                   w_accept;

    // Delays are truncated or zero-extended to the counter width on reload.
    generate
        if (COUNT_WIDTH <= tkpd_pkg::DELAY_WIDTH) begin : g_trunc
            assign w_press_reload   = r_press_delay[COUNT_WIDTH-1:0];
            assign w_unknown_reload = r_unknown_delay[COUNT_WIDTH-1:0];
        end else begin : g_extend
            assign w_press_reload   =
                {{(COUNT_WIDTH-tkpd_pkg::DELAY_WIDTH){1'b0}}, r_press_delay};
            assign w_unknown_reload =
                {{(COUNT_WIDTH-tkpd_pkg::DELAY_WIDTH){1'b0}}, r_unknown_delay};
        end
    endgenerate

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_flags;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_pat = {i_in_data.cold_pin, i_in_data.warm_pin,
                    i_in_data.hot_pin, i_in_data.hotlock_pin};

    always_comb begin
        w_sel        = '0;
        w_is_none    = 1'b0;
        w_is_unknown = 1'b0;
        unique case (w_pat)
            tkpd_pkg::PAT_HOTLOCK: w_sel[tkpd_pkg::SLOT_HOTLOCK] = 1'b1;
            tkpd_pkg::PAT_HOT:     w_sel[tkpd_pkg::SLOT_HOT]     = 1'b1;
            tkpd_pkg::PAT_SODA:    w_sel[tkpd_pkg::SLOT_SODA]    = 1'b1;
            tkpd_pkg::PAT_COOL:    w_sel[tkpd_pkg::SLOT_COOL]    = 1'b1;
            tkpd_pkg::PAT_COMBO:   w_sel[tkpd_pkg::SLOT_COMBO]   = 1'b1;
            tkpd_pkg::PAT_ALL:     w_sel[tkpd_pkg::SLOT_ALL]     = 1'b1;
            tkpd_pkg::PAT_NONE:    w_is_none                     = 1'b1;
            default:               w_is_unknown                  = 1'b1;
        endcase
    end

    always_comb begin
        for (int k = 0; k < NP; k++) begin
            w_zero[k] = (r_cnt[k] == '0);
        end
    end

    assign w_hit_zero     = |(w_sel & w_zero);
    assign w_unknown_fire = w_is_unknown && (r_unknown_cnt == '0);

    // Counter next state.
    always_comb begin
        for (int k = 0; k < NP; k++) begin
            if (w_is_none || w_unknown_fire) begin
                n_cnt[k] = w_press_reload;
            end else if (w_sel[k] && !w_zero[k]) begin
                n_cnt[k] = r_cnt[k] - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            end else begin
                n_cnt[k] = r_cnt[k];
            end
        end
        if (w_is_none) begin
            n_unknown_cnt = w_unknown_reload;
        end else if (w_is_unknown && !w_unknown_fire) begin
            n_unknown_cnt = r_unknown_cnt - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        end else begin
            n_unknown_cnt = r_unknown_cnt;
        end
    end

    // Flag next state.
    always_comb begin
        n_flags = r_flags;
        if (w_is_none) begin
            n_flags = '0;
        end else if (w_unknown_fire) begin
            n_flags.any_pushed = 1'b1;
        end else if (w_hit_zero) begin
            if (!r_flags.any_pushed) begin
                n_flags.any_pushed = 1'b1;
                if (w_sel[tkpd_pkg::SLOT_HOTLOCK]) n_flags.hotlock_press = 1'b1;
                if (w_sel[tkpd_pkg::SLOT_HOT])     n_flags.hot_press     = 1'b1;
                if (w_sel[tkpd_pkg::SLOT_SODA])    n_flags.soda_press    = 1'b1;
                if (w_sel[tkpd_pkg::SLOT_COOL])    n_flags.cool_press    = 1'b1;
                if (w_sel[tkpd_pkg::SLOT_COMBO]) begin
                    n_flags.combo_press = r_flags.combo_press | tkpd_pkg::COMBO_PRESSED;
                end
                if (w_sel[tkpd_pkg::SLOT_ALL])     n_flags.all_press     = 1'b1;
            end else if (w_sel[tkpd_pkg::SLOT_ALL]
                         && r_flags.combo_press == tkpd_pkg::COMBO_PRESSED) begin
                // Adding warm to a combo that already latched promotes it.
                n_flags.combo_press = tkpd_pkg::COMBO_PROMOTED;
            end
        end
        if (i_in_data.hot_pin)  n_flags.hot_press  = 1'b0;
        if (i_in_data.warm_pin) n_flags.soda_press = 1'b0;
        if (i_in_data.cold_pin) n_flags.cool_press = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_delay   <= tkpd_pkg::DELAY_RESET;
            r_unknown_delay <= tkpd_pkg::DELAY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tkpd_pkg::CFG_PRESS_DELAY:   r_press_delay   <= i_cfg_data;
                tkpd_pkg::CFG_UNKNOWN_DELAY: r_unknown_delay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NP; k++) begin
                r_cnt[k] <= '0;
            end
            r_unknown_cnt <= '0;
            r_flags       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                for (int k = 0; k < NP; k++) begin
                    r_cnt[k] <= n_cnt[k];
                end
                r_unknown_cnt <= n_unknown_cnt;
                r_flags       <= n_flags;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
